>>> hdl/rsq_pkg.sv
// Package for the per-flow resequencer: sizes, result codes, word and slot types.
// Used by the channel interfaces and the top level; depends on nothing.
package rsq_pkg;

  localparam int unsigned FLOWS     = 16;
  localparam int unsigned WINDOW    = 16;
  localparam int unsigned SEQ_BITS  = 32;
  localparam int unsigned FLOW_BITS = $clog2(FLOWS);
  localparam int unsigned WIN_BITS  = $clog2(WINDOW);
  localparam int unsigned SLOTS     = FLOWS * WINDOW;
  localparam int unsigned SLOT_BITS = FLOW_BITS + WIN_BITS;
  localparam int unsigned CNT_BITS  = $clog2(WINDOW + 1);
  localparam int unsigned PARK_BITS = 9;

  typedef enum logic [2:0] {
    KIND_DELIVERED = 3'd0,
    KIND_DUPLICATE = 3'd1,
    KIND_PARKED    = 3'd2,
    KIND_SKIPPED   = 3'd3,
    KIND_BEYOND    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [3:0]  flow_index;
    logic [31:0] sequence_req;
    logic [7:0]  operation;
    logic [31:0] payload_handle;
    logic [31:0] key_handle;
    logic        skip_flow;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  out_flow;
    logic [31:0] out_sequence;
    logic [7:0]  out_operation;
    logic [31:0] out_payload;
    logic [31:0] out_key;
    logic        last_of_run;
    logic [31:0] delivered_total;
    logic [31:0] duplicate_total;
    logic [31:0] skipped_total;
    logic [8:0]  parked_now;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  operation;
    logic [31:0] payload;
    logic [31:0] key;
  } slot_t;

endpackage

>>> hdl/rsq_if.sv
// Valid/ready channel interfaces for the resequencer input and result words.
// Depends on rsq_pkg for the word types.
interface rsq_in_if;
  logic               valid;
  logic               ready;
  rsq_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rsq_out_if;
  logic               valid;
  logic               ready;
  rsq_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/per_flow_resequencer_top.sv
// Per-flow resequencer top level: sequencer, slot memory, flow table, output register.
// Depends on rsq_pkg and the channel interfaces in rsq_if.sv.

// A word is captured when taken in IDLE and classified in EVAL against the flow's last
// delivered sequence, which also updates the tables. A delivered word that releases a run
// of parked words moves on to DRAIN, which releases them in turn, paced by the single read
// port of the slot memory, whose read data is registered. The result register lets a new
// word be taken while the last result of the previous one still waits; a stalled consumer
// holds the sequencer. No clearing pass is needed after reset.
module per_flow_resequencer_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  rsq_in_if.sink          in_i,
  rsq_out_if.source       out_o
);

  rsq_pkg::state_e                     state_q, state_d;
  rsq_pkg::in_word_t                   cur_q;
  rsq_pkg::out_word_t                  out_q, out_d;
  logic                                out_valid_q, out_valid_d;
  logic [rsq_pkg::SEQ_BITS-1:0]        last_q [rsq_pkg::FLOWS];
  logic                                last_we;
  logic [rsq_pkg::SEQ_BITS-1:0]        last_wdata;
  logic [rsq_pkg::SLOTS-1:0]           valid_q, valid_d;
  logic [rsq_pkg::CNT_BITS-1:0]        cnt_q, cnt_d;
  logic [31:0]                         dlv_q, dlv_d, dup_q, dup_d, skp_q, skp_d;
  logic [rsq_pkg::PARK_BITS-1:0]       park_q, park_d;

  rsq_pkg::slot_t                      mem [rsq_pkg::SLOTS];
  rsq_pkg::slot_t                      rdata_q;
  logic                                mem_we, mem_re;
  logic [rsq_pkg::SLOT_BITS-1:0]       mem_waddr, mem_raddr;

  logic                                out_free;
  logic [rsq_pkg::FLOW_BITS-1:0]       flow;
  logic [rsq_pkg::SEQ_BITS-1:0]        seq, last, delta, nxt, nxt2;
  logic [rsq_pkg::SLOT_BITS-1:0]       idx_seq, idx_nxt, idx_nxt2;
  logic [rsq_pkg::CNT_BITS:0]          cnt_inc;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == rsq_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign flow     = cur_q.flow_index[rsq_pkg::FLOW_BITS-1:0];
  assign seq      = cur_q.sequence_req[rsq_pkg::SEQ_BITS-1:0];
  assign last     = last_q[flow];
  assign delta    = seq - last;
  assign nxt      = last + 1'b1;
  assign nxt2     = last + 2'd2;
  assign idx_seq  = {flow, seq[rsq_pkg::WIN_BITS-1:0]};
  assign idx_nxt  = {flow, nxt[rsq_pkg::WIN_BITS-1:0]};
  assign idx_nxt2 = {flow, nxt2[rsq_pkg::WIN_BITS-1:0]};
  assign cnt_inc  = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    dlv_d       = dlv_q;
    dup_d       = dup_q;
    skp_d       = skp_q;
    park_d      = park_q;
    last_we     = 1'b0;
    last_wdata  = nxt;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_seq;
    mem_raddr   = idx_nxt2;

    unique case (state_q)
      rsq_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = rsq_pkg::ST_EVAL;
        end
      end
      rsq_pkg::ST_EVAL: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_d                     = '0;
          out_d.out_flow            = cur_q.flow_index;
          out_d.out_sequence        = cur_q.sequence_req;
          out_d.last_of_run         = 1'b1;
          state_d                   = rsq_pkg::ST_IDLE;
          if (cur_q.skip_flow) begin
            skp_d              = skp_q + 1'b1;
            out_d.result_kind  = rsq_pkg::KIND_SKIPPED;
          end else if (seq <= last) begin
            dup_d              = dup_q + 1'b1;
            out_d.result_kind  = rsq_pkg::KIND_DUPLICATE;
          end else if (delta > rsq_pkg::SEQ_BITS'(rsq_pkg::WINDOW)) begin
            out_d.result_kind  = rsq_pkg::KIND_BEYOND;
          end else if (delta != rsq_pkg::SEQ_BITS'(1)) begin
            // park; a repeat only overwrites the data
            mem_we             = 1'b1;
            if (!valid_q[idx_seq]) begin
              valid_d[idx_seq] = 1'b1;
              park_d           = park_q + 1'b1;
            end
            out_d.result_kind  = rsq_pkg::KIND_PARKED;
          end else begin
            last_we              = 1'b1;
            last_wdata           = seq;
            dlv_d                = dlv_q + 1'b1;
            cnt_d                = rsq_pkg::CNT_BITS'(1);
            out_d.result_kind    = rsq_pkg::KIND_DELIVERED;
            out_d.out_operation  = cur_q.operation;
            out_d.out_payload    = cur_q.payload_handle;
            out_d.out_key        = cur_q.key_handle;
            // seq is last + 1 here, so the slot after it is the one at last + 2
            if ((rsq_pkg::WINDOW > 1) && (seq != '1) && valid_q[idx_nxt2]) begin
              out_d.last_of_run = 1'b0;
              mem_re            = 1'b1;
              state_d           = rsq_pkg::ST_DRAIN;
            end
          end
          out_d.delivered_total = dlv_d;
          out_d.duplicate_total = dup_d;
          out_d.skipped_total   = skp_d;
          out_d.parked_now      = park_d;
        end
      end
      rsq_pkg::ST_DRAIN: begin
        if (out_free) begin
          // release the slot whose data was read into rdata_q
          last_we              = 1'b1;
          last_wdata           = nxt;
          valid_d[idx_nxt]     = 1'b0;
          park_d               = park_q - 1'b1;
          dlv_d                = dlv_q + 1'b1;
          cnt_d                = cnt_inc[rsq_pkg::CNT_BITS-1:0];
          out_valid_d          = 1'b1;
          out_d.result_kind    = rsq_pkg::KIND_DELIVERED;
          out_d.out_flow       = cur_q.flow_index;
          out_d.out_sequence   = nxt;
          out_d.out_operation  = rdata_q.operation;
          out_d.out_payload    = rdata_q.payload;
          out_d.out_key        = rdata_q.key;
          out_d.delivered_total = dlv_d;
          out_d.duplicate_total = dup_q;
          out_d.skipped_total   = skp_q;
          out_d.parked_now      = park_d;
          mem_raddr            = idx_nxt2;
          if ((cnt_inc < (rsq_pkg::CNT_BITS+1)'(rsq_pkg::WINDOW)) && (nxt != '1)
              && valid_q[idx_nxt2]) begin
            out_d.last_of_run = 1'b0;
            mem_re            = 1'b1;
          end else begin
            out_d.last_of_run = 1'b1;
            state_d           = rsq_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = rsq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      dlv_q       <= '0;
      dup_q       <= '0;
      skp_q       <= '0;
      park_q      <= '0;
      for (int i = 0; i < rsq_pkg::FLOWS; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      dlv_q       <= dlv_d;
      dup_q       <= dup_d;
      skp_q       <= skp_d;
      park_q      <= park_d;
      if (last_we) begin
        last_q[flow] <= last_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_i.valid && in_i.ready) begin
      cur_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {cur_q.operation, cur_q.payload_handle, cur_q.key_handle};
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == rsq_pkg::ST_EVAL)
    else $error("accepted word not evaluated");
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last_of_run |-> state_q == rsq_pkg::ST_DRAIN)
    else $error("open run without drain");
  a_park_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    park_q <= rsq_pkg::PARK_BITS'(rsq_pkg::SLOTS))
    else $error("parked count overflow");
`endif

endmodule

>>> dv/per_flow_resequencer_top_test.sv
// Self-checking test for the per-flow resequencer: directed and random message streams.
// Depends on rsq_pkg, rsq_if.sv and the per_flow_resequencer_top RTL.
module per_flow_resequencer_top_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  rsq_in_if  in_ch();
  rsq_out_if out_ch();

  per_flow_resequencer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Shadow of the block's per-flow state.
  logic [31:0]          flow_last [rsq_pkg::FLOWS];
  logic                 park_valid [rsq_pkg::SLOTS];
  rsq_pkg::slot_t       park_data [rsq_pkg::SLOTS];
  logic [31:0]          n_delivered, n_duplicate, n_skipped;
  logic [8:0]           n_parked;
  rsq_pkg::out_word_t   expected_words [$];
  int                   errors = 0;
  int                   stall_pct = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    foreach (flow_last[i]) flow_last[i] = '0;
    foreach (park_valid[i]) park_valid[i] = 1'b0;
    n_delivered = '0;
    n_duplicate = '0;
    n_skipped = '0;
    n_parked = '0;
  end

  function automatic rsq_pkg::out_word_t make_word(rsq_pkg::kind_e k, logic [3:0] f,
                                                   logic [31:0] s, rsq_pkg::slot_t d);
    rsq_pkg::out_word_t w;
    w.result_kind     = k;
    w.out_flow        = f;
    w.out_sequence    = s;
    w.out_operation   = d.operation;
    w.out_payload     = d.payload;
    w.out_key         = d.key;
    w.last_of_run     = 1'b0;
    w.delivered_total = n_delivered;
    w.duplicate_total = n_duplicate;
    w.skipped_total   = n_skipped;
    w.parked_now      = n_parked;
    return w;
  endfunction

  // Classify one message and queue the words it should produce.
  function automatic void predict_resequence(rsq_pkg::in_word_t m);
    rsq_pkg::out_word_t run [$];
    rsq_pkg::slot_t     d;
    logic [32:0] delta;
    logic [31:0] nxt;
    int        s;
    d.operation = m.operation;
    d.payload   = m.payload_handle;
    d.key       = m.key_handle;
    if (m.skip_flow || m.flow_index >= rsq_pkg::FLOWS) begin
      n_skipped++;
      run.push_back(make_word(rsq_pkg::KIND_SKIPPED, m.flow_index, m.sequence_req, '0));
    end else if (m.sequence_req <= flow_last[m.flow_index]) begin
      n_duplicate++;
      run.push_back(make_word(rsq_pkg::KIND_DUPLICATE, m.flow_index, m.sequence_req, '0));
    end else begin
      delta = {1'b0, m.sequence_req} - {1'b0, flow_last[m.flow_index]};
      if (delta > rsq_pkg::WINDOW) begin
        run.push_back(make_word(rsq_pkg::KIND_BEYOND, m.flow_index, m.sequence_req, '0));
      end else if (delta > 1) begin
        s = m.flow_index * rsq_pkg::WINDOW + (m.sequence_req % rsq_pkg::WINDOW);
        if (!park_valid[s]) begin
          park_valid[s] = 1'b1;
          n_parked++;
        end
        park_data[s] = d;
        run.push_back(make_word(rsq_pkg::KIND_PARKED, m.flow_index, m.sequence_req, '0));
      end else begin
        flow_last[m.flow_index] = m.sequence_req;
        n_delivered++;
        run.push_back(make_word(rsq_pkg::KIND_DELIVERED, m.flow_index, m.sequence_req, d));
        while (run.size() < rsq_pkg::WINDOW && flow_last[m.flow_index] != 32'hFFFF_FFFF) begin
          nxt = flow_last[m.flow_index] + 1;
          s = m.flow_index * rsq_pkg::WINDOW + (nxt % rsq_pkg::WINDOW);
          if (!park_valid[s]) break;
          park_valid[s] = 1'b0;
          n_parked--;
          flow_last[m.flow_index] = nxt;
          n_delivered++;
          run.push_back(make_word(rsq_pkg::KIND_DELIVERED, m.flow_index, nxt, park_data[s]));
        end
      end
    end
    run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_words.push_back(run[i]);
  endfunction

  // Receiver: random stall pattern, compares each accepted word.
  always @(posedge clk_i) begin
    rsq_pkg::out_word_t e;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, out_ch.data);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_ch.data !== e) begin
            $display("%0t: word mismatch, expected %p, actual %p", $time, e, out_ch.data);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  int burst_left = 0;

  // Valid stays high inside a burst; drop it only for a gap or a drain wait.
  task automatic send_message(rsq_pkg::in_word_t m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_resequence(m);
  endtask

  function automatic rsq_pkg::in_word_t msg(logic [3:0] f, logic [31:0] s,
                                            logic sk = 1'b0);
    rsq_pkg::in_word_t m;
    m.flow_index     = f;
    m.sequence_req   = s;
    m.operation      = 8'($urandom);
    m.payload_handle = $urandom;
    m.key_handle     = $urandom;
    m.skip_flow      = sk;
    return m;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_directed();
    rsq_pkg::in_word_t m;
    send_message(msg(4'd0, 32'd1));
    send_message(msg(4'd0, 32'd0));            // duplicate
    send_message(msg(4'd0, 32'd1, 1'b1));      // skip wins over sequence check
    send_message(msg(4'd1, 32'd17));           // beyond window
    send_message(msg(4'd1, 32'd16));           // parked at window edge
    for (int s = 15; s >= 3; s--) send_message(msg(4'd1, s));
    send_message(msg(4'd1, 32'd3));            // re-park overwrites
    send_message(msg(4'd1, 32'd2));            // parked
    send_message(msg(4'd1, 32'd1));            // full run of WINDOW words
    send_message(msg(4'd1, 32'd17));           // next after run
    m = msg(4'd15, 32'hFFFF_FFFF, 1'b1);
    m.operation = 8'hFF; m.payload_handle = '1; m.key_handle = '1;
    send_message(m);
    m = msg(4'd2, 32'h0); m.operation = '0; m.payload_handle = '0; m.key_handle = '0;
    send_message(m);
    wait_drained();
  endtask

  // Send sequences near the top of sequence space to one flow; both land beyond the window.
  task automatic test_top_of_space();
    flow_last[4'd3] = flow_last[4'd3];
    // Deliver sequences one past last only; reaching the top takes 2^32 steps, so
    // instead exercise the beyond-window path for huge sequences.
    send_message(msg(4'd3, 32'hFFFF_FFFF));
    send_message(msg(4'd3, 32'h8000_0000));
    wait_drained();
  endtask

  task automatic test_random(int count);
    int base_f;
    logic [31:0] s;
    for (int i = 0; i < count; ) begin
      if (i == count / 2) wait_drained();     // hold off until every word is back
      stall_pct = (i % 80 < 20) ? 0 : ((i % 80 < 50) ? 30 : 70);
      base_f = $urandom_range(rsq_pkg::FLOWS - 1);
      case ($urandom_range(9))
        0: begin
          send_message(msg(4'($urandom), $urandom, 1'($urandom)));
          i++;
        end
        1: begin
          send_message(msg(4'(base_f), flow_last[base_f] - $urandom_range(3)));
          i++;
        end
        default: begin
          // reordered burst of future sequences, then the gap filler
          int n;
          n = $urandom_range(rsq_pkg::WINDOW, 2);
          s = flow_last[base_f];
          for (int k = n; k >= 1; k--) begin
            if ($urandom_range(4) != 0)
              send_message(msg(4'(base_f),
                               s + ((k == 1) ? 1 : $urandom_range(rsq_pkg::WINDOW + 1, 2))));
            i++;
          end
          send_message(msg(4'(base_f), s + 1));
          i++;
        end
      endcase
    end
    stall_pct = 0;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_top_of_space();
    test_random(320);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("per_flow_resequencer_top regression: pass");
    end else begin
      $display("per_flow_resequencer_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("per_flow_resequencer_top regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rsq_pkg.sv
hdl/rsq_if.sv
hdl/per_flow_resequencer_top.sv
dv/per_flow_resequencer_top_test.sv
